// ===== hdl/mlz_pkg.sv =====
// mlz_pkg: shared widths, register indexes and types for the z-spectrum evaluator
// no dependencies; used by the csr block, the lanes and the top level
`timescale 1ns / 1ps

package mlz_pkg;

   localparam int FREQ_W  = 32;
   localparam int WIDTH_W = 31;
   localparam int AMP_W   = 20;
   localparam int OUT_W   = 20;
   localparam int BW_W    = 31;
   localparam int CNT_W   = 2;
   localparam int MASK_W  = 3;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int LINE_W  = 21;
   localparam int SUM_W   = 23;
   localparam int DEN_W   = 47;
   localparam int Q_W     = 17;

   // lane pipeline: 9 arithmetic stages, one divider stage per quotient bit, product, sign
   localparam int DIV_FIRST   = 9;
   localparam int LANE_STAGES = DIV_FIRST + Q_W + 2;
   localparam int PIPE_STAGES = LANE_STAGES + 2;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

   // register indexes (byte address divided by four)
   localparam logic [2:0] REG_REF_LEVEL = 3'd0;
   localparam logic [2:0] REG_ADD_MODE  = 3'd1;
   localparam logic [2:0] REG_PULSE_BW  = 3'd2;
   localparam logic [2:0] REG_BAND_MASK = 3'd3;
   localparam logic [2:0] REG_POOL_CNT  = 3'd4;

   typedef struct packed {
      logic signed [OUT_W-1:0] ref_level;
      logic                    add_mode;
      logic [BW_W-1:0]         pulse_bw;
      logic [MASK_W-1:0]       band_mask;
      logic [CNT_W-1:0]        pool_cnt;
   } cfg_type;

   typedef struct packed {
      logic signed [FREQ_W-1:0] offset;
      logic [WIDTH_W-1:0]       fwhm;
      logic signed [AMP_W-1:0]  amp;
   } pool_type;

endpackage

// ===== hdl/mlz_if.sv =====
// mlz_if: valid/ready channel interfaces for frequency points and model results
// depends on mlz_pkg for field widths
`timescale 1ns / 1ps

interface mlz_req_if;
   import mlz_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [FREQ_W-1:0] sat_freq;
   logic signed [FREQ_W-1:0] offset_a;
   logic [WIDTH_W-1:0]       width_a;
   logic signed [AMP_W-1:0]  amp_a;
   logic signed [FREQ_W-1:0] offset_b;
   logic [WIDTH_W-1:0]       width_b;
   logic signed [AMP_W-1:0]  amp_b;
   logic signed [FREQ_W-1:0] offset_c;
   logic [WIDTH_W-1:0]       width_c;
   logic signed [AMP_W-1:0]  amp_c;

   modport source (output valid, sat_freq, offset_a, width_a, amp_a, offset_b, width_b,
                   amp_b, offset_c, width_c, amp_c, input ready);
   modport sink (input valid, sat_freq, offset_a, width_a, amp_a, offset_b, width_b,
                 amp_b, offset_c, width_c, amp_c, output ready);
endinterface

interface mlz_rsp_if;
   import mlz_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] model_value;
   logic                    clipped;

   modport source (output valid, model_value, clipped, input ready);
   modport sink (input valid, model_value, clipped, output ready);
endinterface

// ===== hdl/multi_lorentzian_zspectrum_eval.sv =====
// multi_lorentzian_zspectrum_eval: top level of the multi-pool z-spectrum evaluator
// depends on mlz_pkg, mlz_if, mlz_csr and mlz_lane
//
//   port      | kind         | direction | carries
//   req_chan  | valid/ready  | in        | sat_freq and offset, width, amp of three pools
//   rsp_chan  | valid/ready  | out       | model_value, clipped
//   p*        | apb          | in/out    | five configuration registers
//
// one item per cycle sustained while the result side accepts; each item passes through the
// distance, square, 17 divider, product and sign stages per lane, then the sum and saturation stages.
// reset is synchronous and clears the valid chain and the configuration registers; no clearing pass.
// each stage loads when it is empty or its successor moves, so bubbles collapse and
// a stall on the result side holds every item in place.
`timescale 1ns / 1ps

module multi_lorentzian_zspectrum_eval
   import mlz_pkg::*;
#(
   parameter int MAX_POOLS = 3
)
(
   input  logic              clock,
   input  logic              reset,
   mlz_req_if.sink           req_chan,
   mlz_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;

   mlz_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // valid chain and stage enables
   logic [PIPE_STAGES-1:0] v_ff, v_in, en;

   always_comb begin
      en[PIPE_STAGES-1] = !v_ff[PIPE_STAGES-1] || rsp_chan.ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      if (en[0]) v_in[0] = req_chan.valid;
      else       v_in[0] = v_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         if (en[k]) v_in[k] = v_ff[k-1];
         else       v_in[k] = v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = en[0];

   // pool lanes
   pool_type                 pools [0:2];
   logic signed [LINE_W-1:0] lines [0:MAX_POOLS-1];

   assign pools[0] = '{offset: req_chan.offset_a, fwhm: req_chan.width_a, amp: req_chan.amp_a};
   assign pools[1] = '{offset: req_chan.offset_b, fwhm: req_chan.width_b, amp: req_chan.amp_b};
   assign pools[2] = '{offset: req_chan.offset_c, fwhm: req_chan.width_c, amp: req_chan.amp_c};

   for (genvar i = 0; i < MAX_POOLS; i++) begin : g_lane
      mlz_lane #(.LANE(i)) u_lane (
         .clock    (clock),
         .en       (en[LANE_STAGES-1:0]),
         .cfg      (cfg),
         .sat_freq (req_chan.sat_freq),
         .pool     (pools[i]),
         .line     (lines[i])
      );
   end

   // active pool count, zero counts as one
   logic [CNT_W-1:0] n_pools;

   always_comb begin
      if (cfg.pool_cnt == '0)                     n_pools = CNT_W'(1);
      else if (cfg.pool_cnt > CNT_W'(MAX_POOLS))  n_pools = CNT_W'(MAX_POOLS);
      else                                        n_pools = cfg.pool_cnt;
   end

   // sum of lines around the reference
   logic signed [SUM_W-1:0] sum, sum_ff;

   always_comb begin
      sum = SUM_W'(cfg.ref_level);
      for (int i = 0; i < MAX_POOLS; i++) begin
         if (CNT_W'(i) < n_pools) begin
            if (cfg.add_mode) sum = sum + SUM_W'(lines[i]);
            else              sum = sum - SUM_W'(lines[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[LANE_STAGES]) sum_ff <= sum;
   end

   // saturation into the output register
   logic signed [OUT_W-1:0] value_ff;
   logic                    clip_ff;

   always_ff @(posedge clock) begin
      if (en[LANE_STAGES+1]) begin
         if (sum_ff > SUM_W'(OUT_MAX)) begin
            value_ff <= OUT_MAX;
            clip_ff  <= 1'b1;
         end else if (sum_ff < SUM_W'(OUT_MIN)) begin
            value_ff <= OUT_MIN;
            clip_ff  <= 1'b1;
         end else begin
            value_ff <= sum_ff[OUT_W-1:0];
            clip_ff  <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = v_ff[PIPE_STAGES-1];
   assign rsp_chan.model_value = value_ff;
   assign rsp_chan.clipped     = clip_ff;

endmodule

// ===== hdl/mlz_csr.sv =====
// mlz_csr: apb register block holding the evaluator configuration
// depends on mlz_pkg
`timescale 1ns / 1ps

module mlz_csr
   import mlz_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_REF_LEVEL: cfg_in.ref_level = pwdata[OUT_W-1:0];
            REG_ADD_MODE:  cfg_in.add_mode  = pwdata[0];
            REG_PULSE_BW:  cfg_in.pulse_bw  = pwdata[BW_W-1:0];
            REG_BAND_MASK: cfg_in.band_mask = pwdata[MASK_W-1:0];
            REG_POOL_CNT:  cfg_in.pool_cnt  = pwdata[CNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_level <= 20'sh10000;
         cfg_ff.add_mode  <= 1'b0;
         cfg_ff.pulse_bw  <= '0;
         cfg_ff.band_mask <= '0;
         cfg_ff.pool_cnt  <= CNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_REF_LEVEL: prdata = {{(DATA_W-OUT_W){1'b0}}, cfg_ff.ref_level};
         REG_ADD_MODE:  prdata = {{(DATA_W-1){1'b0}}, cfg_ff.add_mode};
         REG_PULSE_BW:  prdata = {{(DATA_W-BW_W){1'b0}}, cfg_ff.pulse_bw};
         REG_BAND_MASK: prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_ff.band_mask};
         REG_POOL_CNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_ff.pool_cnt};
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/mlz_lane.sv =====
// mlz_lane: pipelined lorentzian line value for one pool, divider one bit per stage
// depends on mlz_pkg; stage enables come from the top level valid chain
`timescale 1ns / 1ps

module mlz_lane
   import mlz_pkg::*;
#(
   parameter int LANE = 0
)
(
   input  logic                     clock,
   input  logic [LANE_STAGES-1:0]   en,
   input  cfg_type                  cfg,
   input  logic signed [FREQ_W-1:0] sat_freq,
   input  pool_type                 pool,
   output logic signed [LINE_W-1:0] line
);

   // stage 0: doubled distance
   logic [FREQ_W+1:0]     d2_ff;
   logic [FREQ_W:0]       diff;
   logic [WIDTH_W-1:0]    a_ff     [0:DIV_FIRST-1];
   logic [AMP_W-1:0]      amp_ff   [0:DIV_FIRST-1];
   logic                  band_ff;

   assign diff = {sat_freq[FREQ_W-1], sat_freq} - {pool.offset[FREQ_W-1], pool.offset};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d2_ff     <= {diff, 1'b0};
         a_ff[0]   <= pool.fwhm;
         amp_ff[0] <= pool.amp;
         band_ff   <= cfg.band_mask[LANE];
      end
   end

   // stage 1: band edges
   logic [FREQ_W+2:0] x_ff, y_ff, bw_ext, d2_ext, fd_ff, fd_sel, xp, yn, b_ff;
   logic [FREQ_W+2:0] fd_abs;

   assign bw_ext = {4'b0, cfg.pulse_bw};
   assign d2_ext = {d2_ff[FREQ_W+1], d2_ff};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x_ff      <= band_ff ? d2_ext - bw_ext : d2_ext;
         y_ff      <= band_ff ? d2_ext + bw_ext : d2_ext;
         a_ff[1]   <= a_ff[0];
         amp_ff[1] <= amp_ff[0];
      end
   end

   // stage 2: distance clipped to zero inside the band
   assign xp     = x_ff[FREQ_W+2] ? '0 : x_ff;
   assign yn     = y_ff[FREQ_W+2] ? y_ff : '0;
   assign fd_sel = (x_ff == y_ff) ? x_ff : xp + yn;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         fd_ff     <= fd_sel;
         a_ff[2]   <= a_ff[1];
         amp_ff[2] <= amp_ff[1];
      end
   end

   // stage 3: magnitude
   assign fd_abs = fd_ff[FREQ_W+2] ? ~fd_ff + 35'd1 : fd_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         b_ff      <= fd_abs;
         a_ff[3]   <= a_ff[2];
         amp_ff[3] <= amp_ff[2];
      end
   end

   // stage 4: bring both operands under 31 bits
   logic [2:0]         sh;
   logic [WIDTH_W-1:0] bn_ff [4:5];
   logic [FREQ_W+2:0]  b_sh;

   always_comb begin
      if (b_ff[34])      sh = 3'd4;
      else if (b_ff[33]) sh = 3'd3;
      else if (b_ff[32]) sh = 3'd2;
      else if (b_ff[31]) sh = 3'd1;
      else               sh = 3'd0;
   end

   assign b_sh = b_ff >> sh;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         a_ff[4]   <= a_ff[3] >> sh;
         bn_ff[4]  <= b_sh[WIDTH_W-1:0];
         amp_ff[4] <= amp_ff[3];
      end
   end

   // stage 5 and 6: squares
   logic [2*WIDTH_W-1:0] sqa_ff [5:6];
   logic [2*WIDTH_W-1:0] sqb_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         sqa_ff[5] <= a_ff[4] * a_ff[4];
         bn_ff[5]  <= bn_ff[4];
         a_ff[5]   <= a_ff[4];
         amp_ff[5] <= amp_ff[4];
      end
      if (en[6]) begin
         sqb_ff    <= bn_ff[5] * bn_ff[5];
         sqa_ff[6] <= sqa_ff[5];
         a_ff[6]   <= a_ff[5];
         amp_ff[6] <= amp_ff[5];
      end
   end

   // stage 7: denominator
   logic [2*WIDTH_W:0] den_ff, num_ff;
   logic               zero_ff [7:DIV_FIRST+Q_W];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         den_ff      <= {1'b0, sqa_ff[6]} + {1'b0, sqb_ff};
         num_ff      <= {1'b0, sqa_ff[6]};
         zero_ff[7]  <= ~|{sqa_ff[6], sqb_ff};
         a_ff[7]     <= a_ff[6];
         amp_ff[7]   <= amp_ff[6];
      end
   end

   // stage 8: scale the fraction under 47 bits
   logic [4:0]         t;
   logic [2*WIDTH_W:0] den_sh, num_sh;
   logic [DEN_W-1:0]   dr_ff [DIV_FIRST-1:DIV_FIRST+Q_W-1];
   logic [DEN_W-1:0]   dd_ff [DIV_FIRST-1:DIV_FIRST+Q_W-1];
   logic [Q_W-1:0]     dq_ff [DIV_FIRST:DIV_FIRST+Q_W-1];
   logic [AMP_W-1:0]   damp_ff [DIV_FIRST-1:DIV_FIRST+Q_W-1];

   always_comb begin
      t = '0;
      for (int k = 0; k < 2*WIDTH_W+1-DEN_W; k++) begin
         if (den_ff[DEN_W+k]) t = 5'(k + 1);
      end
   end

   assign den_sh = den_ff >> t;
   assign num_sh = num_ff >> t;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         dr_ff[8]   <= num_sh[DEN_W-1:0];
         dd_ff[8]   <= den_sh[DEN_W-1:0];
         zero_ff[8] <= zero_ff[7];
         damp_ff[8] <= amp_ff[7];
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 0; j < Q_W; j++) begin : g_div
      localparam int S = DIV_FIRST + j;
      logic [DEN_W:0]   rt, rs;
      logic             ge;
      logic [Q_W-1:0]   qprev;

      assign rt    = (j == 0) ? {1'b0, dr_ff[S-1]} : {dr_ff[S-1], 1'b0};
      assign ge    = rt >= {1'b0, dd_ff[S-1]};
      assign rs    = ge ? rt - {1'b0, dd_ff[S-1]} : rt;
      if (j == 0) begin : g_first
         assign qprev = '0;
      end else begin : g_rest
         assign qprev = dq_ff[S-1];
      end

      always_ff @(posedge clock) begin
         if (en[S]) begin
            dr_ff[S]   <= rs[DEN_W-1:0];
            dd_ff[S]   <= dd_ff[S-1];
            dq_ff[S]   <= {qprev[Q_W-2:0], ge};
            zero_ff[S] <= zero_ff[S-1];
            damp_ff[S] <= damp_ff[S-1];
         end
      end
   end

   // product with the amplitude magnitude, rounded half up
   localparam int LAST = DIV_FIRST + Q_W - 1;
   logic [Q_W-1:0]       g;
   logic [AMP_W-1:0]     mag;
   logic [AMP_W+Q_W-1:0] prod;
   logic [AMP_W-1:0]     q_ff;
   logic                 neg_ff [LAST+1:LAST+1];

   assign g    = zero_ff[LAST] ? 17'h10000 : dq_ff[LAST];
   assign mag  = damp_ff[LAST][AMP_W-1] ? ~damp_ff[LAST] + 20'd1 : damp_ff[LAST];
   assign prod = mag * g + 37'd32768;

   always_ff @(posedge clock) begin
      if (en[LAST+1]) begin
         q_ff           <= prod[AMP_W+15:16];
         neg_ff[LAST+1] <= damp_ff[LAST][AMP_W-1];
      end
   end

   // restore the sign
   logic signed [LINE_W-1:0] line_ff;

   always_ff @(posedge clock) begin
      if (en[LAST+2]) begin
         line_ff <= neg_ff[LAST+1] ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      end
   end

   assign line = line_ff;

endmodule

// ===== hdl/mlz_checker.sv =====
// mlz_checker: port-level checks on the z-spectrum evaluator, bound to the top level
// depends on mlz_pkg
`timescale 1ns / 1ps

module mlz_checker
   import mlz_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] model_value,
   input logic                    clipped,
   input logic                    pready
);

   // nothing left in flight after reset
   a_reset_clears: assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up when the result side is stalled
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");

   // a saturated result sits on a range limit
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && clipped) |-> (model_value == OUT_MAX || model_value == OUT_MIN))
      else $error("clipped flag without a limit value");

   // a stalled result is held until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(model_value) && $stable(clipped)))
      else $error("stalled result changed");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind multi_lorentzian_zspectrum_eval mlz_checker u_mlz_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .model_value (rsp_chan.model_value),
   .clipped     (rsp_chan.clipped),
   .pready      (pready)
);
